[rtl/awen_pkg.sv]
// ---------------------------------------------------------------------------
// awen_pkg
// Shared types, datapath operation codes and constants for the weighted
// error-norm block.
// ---------------------------------------------------------------------------
package awen_pkg;

   localparam int DATA_W = 32;
   localparam int ACC_W  = 64;

   // quantity codes
   localparam logic [1:0] Q_VEL  = 2'd0;
   localparam logic [1:0] Q_VORT = 2'd1;
   localparam logic [1:0] Q_DIVG = 2'd2;
   localparam logic [1:0] Q_END  = 2'd3;

   // configuration register indexes
   localparam logic [1:0] CSR_USE_VEL = 2'd0;
   localparam logic [1:0] CSR_USE_VD  = 2'd1;
   localparam logic [1:0] CSR_WEIGHT  = 2'd2;
   localparam logic [1:0] CSR_REG     = 2'd3;

   localparam logic [DATA_W-1:0] ONE_Q16 = 32'h0001_0000;
   localparam logic [ACC_W-1:0]  SQRT_BIT_TOP = 64'h4000_0000_0000_0000;

   // datapath operations
   localparam logic [4:0] OP_NOP         = 5'd0;
   localparam logic [4:0] OP_LOAD        = 5'd1;
   localparam logic [4:0] OP_MUL_WREG    = 5'd2;
   localparam logic [4:0] OP_DVD_SET     = 5'd3;
   localparam logic [4:0] OP_DIV_SCALE   = 5'd4;
   localparam logic [4:0] OP_DIV_STEP    = 5'd5;
   localparam logic [4:0] OP_SCALE_SAVE  = 5'd6;
   localparam logic [4:0] OP_MAG_SCALAR  = 5'd7;
   localparam logic [4:0] OP_MUL_SQ      = 5'd8;
   localparam logic [4:0] OP_SQ_FIRST    = 5'd9;
   localparam logic [4:0] OP_SQ_ADD      = 5'd10;
   localparam logic [4:0] OP_SQRT_SQA    = 5'd11;
   localparam logic [4:0] OP_SQRT_STEP   = 5'd12;
   localparam logic [4:0] OP_MAG_SAVE    = 5'd13;
   localparam logic [4:0] OP_MUL_MAG     = 5'd14;
   localparam logic [4:0] OP_MUL_AREA_LO = 5'd15;
   localparam logic [4:0] OP_MUL_AREA_HI = 5'd16;
   localparam logic [4:0] OP_TERM        = 5'd17;
   localparam logic [4:0] OP_ACC         = 5'd18;
   localparam logic [4:0] OP_DIV_RMS     = 5'd19;
   localparam logic [4:0] OP_SQRT_QUO    = 5'd20;
   localparam logic [4:0] OP_RMS_SAVE    = 5'd21;
   localparam logic [4:0] OP_RSP_LOAD    = 5'd22;
   localparam logic [4:0] OP_CLEAR       = 5'd23;

   typedef struct packed {
      logic [4:0] op;
      logic [1:0] q;   // quantity
      logic       s;   // side: 0 error, 1 reference (or component)
      logic       c;   // velocity component
   } cmd_type;

   typedef struct packed {
      logic in_domain;
      logic last;
      logic use_vel;
      logic use_vd;
      logic zero_area;
   } sts_type;

endpackage

[rtl/awen_ctrl.sv]
// ---------------------------------------------------------------------------
// awen_ctrl
// Sequencer: walks the datapath through scaling divisions, magnitudes,
// weighted accumulation and the final RMS divisions and roots.
// ---------------------------------------------------------------------------
module awen_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   input  awen_pkg::sts_type   sts,
   output awen_pkg::cmd_type   cmd
);

   localparam logic [4:0] ST_IDLE   = 5'd0;
   localparam logic [4:0] ST_WMUL   = 5'd1;
   localparam logic [4:0] ST_DVD    = 5'd2;
   localparam logic [4:0] ST_QSEL   = 5'd3;
   localparam logic [4:0] ST_DIV    = 5'd4;
   localparam logic [4:0] ST_DSTEP  = 5'd5;
   localparam logic [4:0] ST_DSAVE  = 5'd6;
   localparam logic [4:0] ST_MAGS   = 5'd7;
   localparam logic [4:0] ST_SQ1    = 5'd8;
   localparam logic [4:0] ST_SQ2    = 5'd9;
   localparam logic [4:0] ST_SQ3    = 5'd10;
   localparam logic [4:0] ST_SQ4    = 5'd11;
   localparam logic [4:0] ST_SQRT   = 5'd12;
   localparam logic [4:0] ST_SSTEP  = 5'd13;
   localparam logic [4:0] ST_MSAVE  = 5'd14;
   localparam logic [4:0] ST_W1     = 5'd15;
   localparam logic [4:0] ST_W2     = 5'd16;
   localparam logic [4:0] ST_W3     = 5'd17;
   localparam logic [4:0] ST_W4     = 5'd18;
   localparam logic [4:0] ST_W5     = 5'd19;
   localparam logic [4:0] ST_FIN    = 5'd20;
   localparam logic [4:0] ST_RQ     = 5'd21;
   localparam logic [4:0] ST_RDIV   = 5'd22;
   localparam logic [4:0] ST_RDSTEP = 5'd23;
   localparam logic [4:0] ST_RSQRT  = 5'd24;
   localparam logic [4:0] ST_RSSTEP = 5'd25;
   localparam logic [4:0] ST_RSAVE  = 5'd26;
   localparam logic [4:0] ST_RSP    = 5'd27;
   localparam logic [4:0] ST_RWAIT  = 5'd28;
   localparam logic [4:0] ST_CLR    = 5'd29;

   localparam logic [5:0] DIV_LAST  = 6'd63;
   localparam logic [5:0] SQRT_LAST = 6'd31;

   logic [4:0] state_ff, state_in;
   logic [1:0] q_ff, q_in;
   logic       s_ff, s_in;
   logic [5:0] cnt_ff, cnt_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       q_enabled;

   assign rsp_valid = rsp_valid_ff;
   assign q_enabled = (q_ff == awen_pkg::Q_VEL) ? sts.use_vel : sts.use_vd;

   always_comb begin
      state_in     = state_ff;
      q_in         = q_ff;
      s_in         = s_ff;
      cnt_in       = cnt_ff;
      rsp_valid_in = rsp_valid_ff;
      req_ready    = 1'b0;
      cmd.op       = awen_pkg::OP_NOP;
      cmd.q        = q_ff;
      cmd.s        = s_ff;
      cmd.c        = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.op   = awen_pkg::OP_LOAD;
               state_in = ST_WMUL;
            end
         end
         ST_WMUL: begin
            cmd.op   = awen_pkg::OP_MUL_WREG;
            state_in = ST_DVD;
         end
         ST_DVD: begin
            cmd.op   = awen_pkg::OP_DVD_SET;
            state_in = ST_QSEL;
         end
         ST_QSEL: begin
            if (!sts.in_domain || q_ff == awen_pkg::Q_END) begin
               q_in     = awen_pkg::Q_VEL;
               state_in = ST_FIN;
            end else if (q_enabled) begin
               state_in = ST_DIV;
            end else begin
               q_in = q_ff + 2'd1;
            end
         end
         ST_DIV: begin
            cmd.op   = awen_pkg::OP_DIV_SCALE;
            cnt_in   = '0;
            state_in = ST_DSTEP;
         end
         ST_DSTEP: begin
            cmd.op = awen_pkg::OP_DIV_STEP;
            cnt_in = cnt_ff + 6'd1;
            if (cnt_ff == DIV_LAST) begin
               state_in = ST_DSAVE;
            end
         end
         ST_DSAVE: begin
            cmd.op = awen_pkg::OP_SCALE_SAVE;
            if (q_ff == awen_pkg::Q_VEL && !s_ff) begin
               s_in     = 1'b1;
               state_in = ST_DIV;
            end else if (q_ff == awen_pkg::Q_VEL) begin
               s_in     = 1'b0;
               state_in = ST_SQ1;
            end else begin
               state_in = ST_MAGS;
            end
         end
         ST_MAGS: begin
            cmd.op   = awen_pkg::OP_MAG_SCALAR;
            s_in     = 1'b0;
            state_in = ST_W1;
         end
         ST_SQ1: begin
            cmd.op   = awen_pkg::OP_MUL_SQ;
            state_in = ST_SQ2;
         end
         ST_SQ2: begin
            cmd.op   = awen_pkg::OP_SQ_FIRST;
            state_in = ST_SQ3;
         end
         ST_SQ3: begin
            cmd.op   = awen_pkg::OP_MUL_SQ;
            cmd.c    = 1'b1;
            state_in = ST_SQ4;
         end
         ST_SQ4: begin
            cmd.op   = awen_pkg::OP_SQ_ADD;
            state_in = ST_SQRT;
         end
         ST_SQRT: begin
            cmd.op   = awen_pkg::OP_SQRT_SQA;
            cnt_in   = '0;
            state_in = ST_SSTEP;
         end
         ST_SSTEP: begin
            cmd.op = awen_pkg::OP_SQRT_STEP;
            cnt_in = cnt_ff + 6'd1;
            if (cnt_ff == SQRT_LAST) begin
               cnt_in   = '0;
               state_in = ST_MSAVE;
            end
         end
         ST_MSAVE: begin
            cmd.op = awen_pkg::OP_MAG_SAVE;
            if (!s_ff) begin
               s_in     = 1'b1;
               state_in = ST_SQ1;
            end else begin
               s_in     = 1'b0;
               state_in = ST_W1;
            end
         end
         ST_W1: begin
            cmd.op   = awen_pkg::OP_MUL_MAG;
            state_in = ST_W2;
         end
         ST_W2: begin
            cmd.op   = awen_pkg::OP_MUL_AREA_LO;
            state_in = ST_W3;
         end
         ST_W3: begin
            cmd.op   = awen_pkg::OP_MUL_AREA_HI;
            state_in = ST_W4;
         end
         ST_W4: begin
            cmd.op   = awen_pkg::OP_TERM;
            state_in = ST_W5;
         end
         ST_W5: begin
            cmd.op = awen_pkg::OP_ACC;
            if (!s_ff) begin
               s_in     = 1'b1;
               state_in = ST_W1;
            end else begin
               s_in     = 1'b0;
               q_in     = q_ff + 2'd1;
               state_in = ST_QSEL;
            end
         end
         ST_FIN: begin
            q_in = awen_pkg::Q_VEL;
            s_in = 1'b0;
            if (sts.last) begin
               state_in = ST_RQ;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_RQ: begin
            // no division when nothing was accumulated: RMS is forced to zero
            if (sts.zero_area) begin
               state_in = ST_RSP;
            end else begin
               state_in = ST_RDIV;
            end
         end
         ST_RDIV: begin
            cmd.op   = awen_pkg::OP_DIV_RMS;
            cnt_in   = '0;
            state_in = ST_RDSTEP;
         end
         ST_RDSTEP: begin
            cmd.op = awen_pkg::OP_DIV_STEP;
            cnt_in = cnt_ff + 6'd1;
            if (cnt_ff == DIV_LAST) begin
               state_in = ST_RSQRT;
            end
         end
         ST_RSQRT: begin
            cmd.op   = awen_pkg::OP_SQRT_QUO;
            cnt_in   = '0;
            state_in = ST_RSSTEP;
         end
         ST_RSSTEP: begin
            cmd.op = awen_pkg::OP_SQRT_STEP;
            cnt_in = cnt_ff + 6'd1;
            if (cnt_ff == SQRT_LAST) begin
               cnt_in   = '0;
               state_in = ST_RSAVE;
            end
         end
         ST_RSAVE: begin
            cmd.op = awen_pkg::OP_RMS_SAVE;
            if (!s_ff) begin
               s_in     = 1'b1;
               state_in = ST_RDIV;
            end else begin
               s_in     = 1'b0;
               state_in = ST_RSP;
            end
         end
         ST_RSP: begin
            cmd.op       = awen_pkg::OP_RSP_LOAD;
            rsp_valid_in = 1'b1;
            state_in     = ST_RWAIT;
         end
         ST_RWAIT: begin
            if (rsp_ready) begin
               rsp_valid_in = 1'b0;
               if (q_ff == awen_pkg::Q_DIVG) begin
                  state_in = ST_CLR;
               end else begin
                  q_in     = q_ff + 2'd1;
                  state_in = ST_RQ;
               end
            end
         end
         ST_CLR: begin
            cmd.op   = awen_pkg::OP_CLEAR;
            q_in     = awen_pkg::Q_VEL;
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         q_ff         <= awen_pkg::Q_VEL;
         s_ff         <= 1'b0;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         q_ff         <= q_in;
         s_ff         <= s_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      !(req_ready && rsp_valid_ff))
      else $error("input taken while a result is pending");

   a_clear_after_last: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_RWAIT && rsp_ready && q_ff == awen_pkg::Q_DIVG)
      |=> state_ff == ST_CLR)
      else $error("state not cleared after the divergence result");

   a_idle_quantity: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_IDLE |-> (q_ff == awen_pkg::Q_VEL && !s_ff))
      else $error("sequencer indexes not rewound in idle");

   a_result_held: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> state_ff == ST_RWAIT)
      else $error("result valid outside the wait state");

endmodule

[rtl/awen_dpath.sv]
// ---------------------------------------------------------------------------
// awen_dpath
// Datapath: item registers, shared 32x32 multiplier, bit-serial divider,
// bit-serial square root, accumulators and result registers.
// ---------------------------------------------------------------------------
module awen_dpath (
   input  logic                clock,
   input  logic                reset,
   input  awen_pkg::cmd_type   cmd,
   output awen_pkg::sts_type   sts,
   input  logic                csr_valid,
   input  logic [1:0]          csr_index,
   input  logic [31:0]         csr_data,
   input  logic                req_in_domain,
   input  logic [31:0]         req_cell_area,
   input  logic signed [31:0]  req_model_u,
   input  logic signed [31:0]  req_model_v,
   input  logic signed [31:0]  req_model_vort,
   input  logic signed [31:0]  req_model_div,
   input  logic signed [31:0]  req_ref_u,
   input  logic signed [31:0]  req_ref_v,
   input  logic signed [31:0]  req_ref_vort,
   input  logic signed [31:0]  req_ref_div,
   input  logic                req_last_point,
   output logic [1:0]          rsp_quantity,
   output logic [31:0]         rsp_rms_error,
   output logic [31:0]         rsp_max_error,
   output logic [31:0]         rsp_rms_reference,
   output logic [31:0]         rsp_max_reference,
   output logic                rsp_zero_area,
   output logic                rsp_last_result
);

   localparam int DW = awen_pkg::DATA_W;
   localparam int AW = awen_pkg::ACC_W;

   function automatic logic [DW-1:0] abs33(input logic [DW:0] v);
      logic [DW:0] n;
      n = ~v + {{DW{1'b0}}, 1'b1};
      abs33 = v[DW] ? n[DW-1:0] : v[DW-1:0];
   endfunction

   function automatic logic [DW-1:0] abs32(input logic [DW-1:0] v);
      abs32 = v[DW-1] ? (~v + {{(DW-1){1'b0}}, 1'b1}) : v;
   endfunction

   // configuration and accumulated state
   logic          use_vel_ff, use_vd_ff, weight_ff;
   logic [DW-1:0] regf_ff;
   logic          dom_ff, last_ff;
   logic [AW-1:0] area_tot_ff;
   logic [AW-1:0] sqe_ff [3];
   logic [AW-1:0] sqr_ff [3];
   logic [DW-1:0] emax_ff [3];
   logic [DW-1:0] rmax_ff [3];

   // item and working registers
   logic [DW-1:0] area_ff;
   logic [DW-1:0] model_ff [4];
   logic [DW-1:0] ref_ff [4];
   logic [AW-1:0] mul_ff, dvd_ff, plo_ff, term_ff;
   logic [DW-1:0] sqh_ff;
   logic [AW-1:0] rem_ff, nl_ff, quo_ff, dsr_ff;
   logic          dsat_ff, sc_neg_ff, sc_zero_ff;
   logic [DW-1:0] scaled_ff [2];
   logic [DW-1:0] emag_ff, rmag_ff;
   logic [AW:0]   sqa_ff;
   logic [AW-1:0] sn_ff, sres_ff, sbit_ff;
   logic          ssat_ff;
   logic [DW-1:0] rms_e_ff, rms_r_ff;

   // combinational
   logic [DW-1:0] w_val, m_val, m_mag, r_sc, e_abs, r_abs, sq_op, mag_w;
   logic [DW-1:0] mul_a, mul_b, scaled_in, mag_in;
   logic [1:0]    midx, ridx;
   logic [AW-1:0] mul_p, d_scale, rem_sh, rem_in, q_raw, q_lim, lim;
   logic          sub_ok, mul_load, s_ge;
   logic [AW-1:0] s_t, prod_hi, term_in, acc_old, acc_in, area_in, rq_nh;
   logic [AW:0]   acc_sum, area_sum;
   logic [DW:0]   e_sc, eu, ev;

   always_comb begin
      w_val   = weight_ff ? area_ff : awen_pkg::ONE_Q16;
      midx    = (cmd.q == awen_pkg::Q_VEL)  ? {1'b0, cmd.s} :
                (cmd.q == awen_pkg::Q_VORT) ? 2'd2 : 2'd3;
      m_val   = model_ff[midx];
      m_mag   = abs32(m_val);
      d_scale = (cmd.q == awen_pkg::Q_VEL) ? {16'd0, w_val, 16'd0} : dvd_ff;

      // one restoring division step
      rem_sh = {rem_ff[AW-2:0], nl_ff[AW-1]};
      sub_ok = rem_ff[AW-1] | (rem_sh >= dsr_ff);
      rem_in = sub_ok ? (rem_sh - dsr_ff) : rem_sh;

      // saturate scaled quotient to the signed range of the model's sign
      q_raw     = dsat_ff ? '1 : quo_ff;
      lim       = sc_neg_ff ? 64'h0000_0000_8000_0000 : 64'h0000_0000_7FFF_FFFF;
      q_lim     = sc_zero_ff ? '0 : ((q_raw > lim) ? lim : q_raw);
      scaled_in = sc_neg_ff ? (~q_lim[DW-1:0] + 32'd1) : q_lim[DW-1:0];

      ridx  = (cmd.q == awen_pkg::Q_VORT) ? 2'd2 : 2'd3;
      r_sc  = ref_ff[ridx];
      e_sc  = {scaled_ff[0][DW-1], scaled_ff[0]} - {r_sc[DW-1], r_sc};
      e_abs = abs33(e_sc);
      r_abs = abs32(r_sc);

      eu = {scaled_ff[0][DW-1], scaled_ff[0]} - {ref_ff[0][DW-1], ref_ff[0]};
      ev = {scaled_ff[1][DW-1], scaled_ff[1]} - {ref_ff[1][DW-1], ref_ff[1]};
      case ({cmd.s, cmd.c})
         2'b00:   sq_op = abs33(eu);
         2'b01:   sq_op = abs33(ev);
         2'b10:   sq_op = abs32(ref_ff[0]);
         default: sq_op = abs32(ref_ff[1]);
      endcase

      mag_w = cmd.s ? rmag_ff : emag_ff;

      mul_load = 1'b1;
      case (cmd.op)
         awen_pkg::OP_MUL_WREG: begin
            mul_a = w_val;
            mul_b = regf_ff;
         end
         awen_pkg::OP_MUL_SQ: begin
            mul_a = sq_op;
            mul_b = sq_op;
         end
         awen_pkg::OP_MUL_MAG: begin
            mul_a = mag_w;
            mul_b = mag_w;
         end
         awen_pkg::OP_MUL_AREA_LO: begin
            mul_a = area_ff;
            mul_b = mul_ff[DW-1:0];
         end
         awen_pkg::OP_MUL_AREA_HI: begin
            mul_a = area_ff;
            mul_b = sqh_ff;
         end
         default: begin
            mul_a    = '0;
            mul_b    = '0;
            mul_load = 1'b0;
         end
      endcase
      mul_p = AW'(mul_a) * AW'(mul_b);

      // one square-root step
      s_t  = sres_ff + sbit_ff;
      s_ge = sn_ff >= s_t;

      // (area * mag^2) >> 16 from two partial products
      prod_hi = mul_ff + {32'd0, plo_ff[AW-1:DW]};
      term_in = (prod_hi[AW-1:48] != 16'd0) ? '1 : {prod_hi[47:0], plo_ff[DW-1:16]};

      acc_old = cmd.s ? sqr_ff[cmd.q] : sqe_ff[cmd.q];
      acc_sum = {1'b0, acc_old} + {1'b0, term_ff};
      acc_in  = acc_sum[AW] ? '1 : acc_sum[AW-1:0];

      area_sum = {1'b0, area_tot_ff} + {33'd0, req_cell_area};
      area_in  = area_sum[AW] ? '1 : area_sum[AW-1:0];

      rq_nh  = {48'd0, acc_old[AW-1:48]};
      mag_in = ssat_ff ? '1 : sres_ff[DW-1:0];
   end

   always_comb begin
      sts.in_domain = dom_ff;
      sts.last      = last_ff;
      sts.use_vel   = use_vel_ff;
      sts.use_vd    = use_vd_ff;
      sts.zero_area = (area_tot_ff == '0);
   end

   // configuration, item flags and accumulators
   always_ff @(posedge clock) begin
      if (reset) begin
         use_vel_ff  <= 1'b1;
         use_vd_ff   <= 1'b1;
         weight_ff   <= 1'b0;
         regf_ff     <= awen_pkg::ONE_Q16;
         dom_ff      <= 1'b0;
         last_ff     <= 1'b0;
         area_tot_ff <= '0;
         for (int i = 0; i < 3; i++) begin
            sqe_ff[i]  <= '0;
            sqr_ff[i]  <= '0;
            emax_ff[i] <= '0;
            rmax_ff[i] <= '0;
         end
      end else begin
         if (csr_valid) begin
            case (csr_index)
               awen_pkg::CSR_USE_VEL: use_vel_ff <= csr_data[0];
               awen_pkg::CSR_USE_VD:  use_vd_ff  <= csr_data[0];
               awen_pkg::CSR_WEIGHT:  weight_ff  <= csr_data[0];
               awen_pkg::CSR_REG:     regf_ff    <= csr_data;
               default: ;
            endcase
         end
         case (cmd.op)
            awen_pkg::OP_LOAD: begin
               dom_ff  <= req_in_domain;
               last_ff <= req_last_point;
               if (req_in_domain) begin
                  area_tot_ff <= area_in;
               end
            end
            awen_pkg::OP_ACC: begin
               if (cmd.s) begin
                  sqr_ff[cmd.q] <= acc_in;
                  if (rmag_ff > rmax_ff[cmd.q]) begin
                     rmax_ff[cmd.q] <= rmag_ff;
                  end
               end else begin
                  sqe_ff[cmd.q] <= acc_in;
                  if (emag_ff > emax_ff[cmd.q]) begin
                     emax_ff[cmd.q] <= emag_ff;
                  end
               end
            end
            awen_pkg::OP_CLEAR: begin
               area_tot_ff <= '0;
               for (int i = 0; i < 3; i++) begin
                  sqe_ff[i]  <= '0;
                  sqr_ff[i]  <= '0;
                  emax_ff[i] <= '0;
                  rmax_ff[i] <= '0;
               end
            end
            default: ;
         endcase
      end
   end

   // working registers
   always_ff @(posedge clock) begin
      if (mul_load) begin
         mul_ff <= mul_p;
      end
      case (cmd.op)
         awen_pkg::OP_LOAD: begin
            area_ff     <= req_cell_area;
            model_ff[0] <= req_model_u;
            model_ff[1] <= req_model_v;
            model_ff[2] <= req_model_vort;
            model_ff[3] <= req_model_div;
            ref_ff[0]   <= req_ref_u;
            ref_ff[1]   <= req_ref_v;
            ref_ff[2]   <= req_ref_vort;
            ref_ff[3]   <= req_ref_div;
         end
         awen_pkg::OP_DVD_SET: dvd_ff <= mul_ff;
         awen_pkg::OP_DIV_SCALE: begin
            rem_ff     <= '0;
            nl_ff      <= {m_mag, 32'd0};
            quo_ff     <= '0;
            dsr_ff     <= d_scale;
            dsat_ff    <= (d_scale == '0);
            sc_neg_ff  <= m_val[DW-1];
            sc_zero_ff <= (m_mag == '0);
         end
         awen_pkg::OP_DIV_RMS: begin
            rem_ff  <= rq_nh;
            nl_ff   <= {acc_old[47:0], 16'd0};
            quo_ff  <= '0;
            dsr_ff  <= area_tot_ff;
            dsat_ff <= (rq_nh >= area_tot_ff);
         end
         awen_pkg::OP_DIV_STEP: begin
            rem_ff <= rem_in;
            nl_ff  <= {nl_ff[AW-2:0], 1'b0};
            quo_ff <= {quo_ff[AW-2:0], sub_ok};
         end
         awen_pkg::OP_SCALE_SAVE: scaled_ff[cmd.s] <= scaled_in;
         awen_pkg::OP_MAG_SCALAR: begin
            emag_ff <= e_abs;
            rmag_ff <= r_abs;
         end
         awen_pkg::OP_SQ_FIRST: sqa_ff <= {1'b0, mul_ff};
         awen_pkg::OP_SQ_ADD:   sqa_ff <= {1'b0, sqa_ff[AW-1:0]} + {1'b0, mul_ff};
         awen_pkg::OP_SQRT_SQA: begin
            sn_ff   <= sqa_ff[AW-1:0];
            ssat_ff <= sqa_ff[AW];
            sres_ff <= '0;
            sbit_ff <= awen_pkg::SQRT_BIT_TOP;
         end
         awen_pkg::OP_SQRT_QUO: begin
            sn_ff   <= dsat_ff ? '1 : quo_ff;
            ssat_ff <= 1'b0;
            sres_ff <= '0;
            sbit_ff <= awen_pkg::SQRT_BIT_TOP;
         end
         awen_pkg::OP_SQRT_STEP: begin
            if (s_ge) begin
               sn_ff   <= sn_ff - s_t;
               sres_ff <= (sres_ff >> 1) + sbit_ff;
            end else begin
               sres_ff <= sres_ff >> 1;
            end
            sbit_ff <= sbit_ff >> 2;
         end
         awen_pkg::OP_MAG_SAVE: begin
            if (cmd.s) begin
               rmag_ff <= mag_in;
            end else begin
               emag_ff <= mag_in;
            end
         end
         awen_pkg::OP_MUL_AREA_LO: sqh_ff <= mul_ff[AW-1:DW];
         awen_pkg::OP_MUL_AREA_HI: plo_ff <= mul_ff;
         awen_pkg::OP_TERM:        term_ff <= term_in;
         awen_pkg::OP_RMS_SAVE: begin
            if (cmd.s) begin
               rms_r_ff <= sres_ff[DW-1:0];
            end else begin
               rms_e_ff <= sres_ff[DW-1:0];
            end
         end
         awen_pkg::OP_RSP_LOAD: begin
            rsp_quantity      <= cmd.q;
            rsp_rms_error     <= sts.zero_area ? '0 : rms_e_ff;
            rsp_max_error     <= emax_ff[cmd.q];
            rsp_rms_reference <= sts.zero_area ? '0 : rms_r_ff;
            rsp_max_reference <= rmax_ff[cmd.q];
            rsp_zero_area     <= sts.zero_area;
            rsp_last_result   <= (cmd.q == awen_pkg::Q_DIVG);
         end
         default: ;
      endcase
   end

endmodule

[rtl/area_weighted_error_norms.sv]
// ---------------------------------------------------------------------------
// area_weighted_error_norms
// Area-weighted RMS and max error norms for velocity, vorticity and
// divergence over a stream of grid points, in signed Q16.16.
// ---------------------------------------------------------------------------
//   channel   handshake             direction  carries
//   req_      req_valid/req_ready   in         one grid point per item
//   rsp_      rsp_valid/rsp_ready   out        one norm set per quantity
//   csr_      csr_valid/csr_ready   in         register index and data
//
// A point is taken only in idle and worked through one shared multiplier,
// a one-bit-per-cycle divider and a two-bit-per-cycle root. An out-of-domain
// point skips the per-quantity work, as does a quantity switched off. After
// the last point the three results are offered one after another, each held
// until rsp_ready; with zero total area the divisions and roots are skipped.
// Reset is synchronous; accumulators are cleared by reset and after the
// divergence result. csr_ready is always high.
// ---------------------------------------------------------------------------
module area_weighted_error_norms (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic                req_in_domain,
   input  logic [31:0]         req_cell_area,
   input  logic signed [31:0]  req_model_u,
   input  logic signed [31:0]  req_model_v,
   input  logic signed [31:0]  req_model_vort,
   input  logic signed [31:0]  req_model_div,
   input  logic signed [31:0]  req_ref_u,
   input  logic signed [31:0]  req_ref_v,
   input  logic signed [31:0]  req_ref_vort,
   input  logic signed [31:0]  req_ref_div,
   input  logic                req_last_point,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic [1:0]          rsp_quantity,
   output logic [31:0]         rsp_rms_error,
   output logic [31:0]         rsp_max_error,
   output logic [31:0]         rsp_rms_reference,
   output logic [31:0]         rsp_max_reference,
   output logic                rsp_zero_area,
   output logic                rsp_last_result,
   input  logic                csr_valid,
   output logic                csr_ready,
   input  logic [1:0]          csr_index,
   input  logic [31:0]         csr_data
);

   awen_pkg::cmd_type cmd;
   awen_pkg::sts_type sts;

   assign csr_ready = 1'b1;

   awen_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   awen_dpath u_dpath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .sts               (sts),
      .csr_valid         (csr_valid),
      .csr_index         (csr_index),
      .csr_data          (csr_data),
      .req_in_domain     (req_in_domain),
      .req_cell_area     (req_cell_area),
      .req_model_u       (req_model_u),
      .req_model_v       (req_model_v),
      .req_model_vort    (req_model_vort),
      .req_model_div     (req_model_div),
      .req_ref_u         (req_ref_u),
      .req_ref_v         (req_ref_v),
      .req_ref_vort      (req_ref_vort),
      .req_ref_div       (req_ref_div),
      .req_last_point    (req_last_point),
      .rsp_quantity      (rsp_quantity),
      .rsp_rms_error     (rsp_rms_error),
      .rsp_max_error     (rsp_max_error),
      .rsp_rms_reference (rsp_rms_reference),
      .rsp_max_reference (rsp_max_reference),
      .rsp_zero_area     (rsp_zero_area),
      .rsp_last_result   (rsp_last_result)
   );

endmodule
